// ===== sv/fa_pkg.sv =====
// ----------------------------------------------------------------------------
// fa_pkg
// shared types, widths and constants of the atan2 angle block
// ----------------------------------------------------------------------------
package fa_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 16;

    localparam int C_W     = FRAC_BITS + 1;     // ratio, 0 .. 1.0 inclusive
    localparam int COEF_W  = 24;
    localparam int ACC_W   = COEF_W + 4;
    localparam int PRD_W   = ACC_W + C_W + 1;
    localparam int FLD_W   = ACC_W + 2;
    localparam int ANG_W   = 25;
    localparam int RAD_K_W = 27;
    localparam int RAD_P_W = ANG_W + RAD_K_W;
    localparam int RAD_Q_W = RAD_P_W - 32;
    localparam int CFG_I_W = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;
    localparam int BK_STG  = 12;

    localparam logic [FLD_W-1:0]   DEG90     = FLD_W'(90 * 65536);
    localparam logic [FLD_W-1:0]   DEG180    = FLD_W'(180 * 65536);
    localparam logic [FLD_W-1:0]   DEG360    = FLD_W'(360 * 65536);
    localparam logic [ANG_W-1:0]   ANGLE_MAX = ANG_W'(23592960);
    localparam logic [RAD_K_W-1:0] DEG_TO_RAD = RAD_K_W'(74961321);
    localparam logic [PRD_W-1:0]   RND_HALF  = PRD_W'(1) << (FRAC_BITS - 1);
    localparam logic [RAD_P_W:0]   RAD_HALF  = (RAD_P_W + 1)'(1) << 31;

    localparam logic [COEF_W-1:0] RST_COEF1 = COEF_W'(3754140);
    localparam logic [COEF_W-1:0] RST_COEF3 = COEF_W'(-1223390);
    localparam logic [COEF_W-1:0] RST_COEF5 = COEF_W'(584188);
    localparam logic [COEF_W-1:0] RST_COEF7 = COEF_W'(-166443);

    typedef enum logic [CFG_I_W-1:0] {
        CFG_DEGREE_MODE = 3'd0,
        CFG_COEF_FIRST  = 3'd1,
        CFG_COEF_THIRD  = 3'd2,
        CFG_COEF_FIFTH  = 3'd3,
        CFG_COEF_SEVENTH = 3'd4
    } cfg_idx_t;

    // octant flags that ride along with each word
    typedef struct packed {
        logic steep;
        logic xneg;
        logic yneg;
        logic last;
    } tag_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [IN_WIDTH-1:0] mn;
        logic [IN_WIDTH-1:0] mx;
        tag_t                tag;
    } item_t;

    typedef struct packed {
        logic                       degree_mode;
        logic signed [COEF_W-1:0]   coef1;
        logic signed [COEF_W-1:0]   coef3;
        logic signed [COEF_W-1:0]   coef5;
        logic signed [COEF_W-1:0]   coef7;
    } cfg_t;

endpackage

// ===== sv/fast_atan2_angle.sv =====
// ----------------------------------------------------------------------------
// fast_atan2_angle
// gradient orientation by a degree-7 polynomial atan2 in fixed point
// ----------------------------------------------------------------------------
// takes one (grad_x, grad_y) word per cycle while the output is not stalled and
// returns its angle as unsigned Q9.16, 0 to 360 degrees, or radians when
// degree_mode is 0. throughput is one word per clock while the output is not
// stalled. the path runs through the front register, the fifo write, the
// 17-stage divider that forms min/max one quotient bit per stage, then the
// square, four multiply and round-add pairs of the polynomial, the octant fold,
// saturation, the radian multiply and the output register. a front register and
// a 4-word fifo sit ahead of the back pipeline, so up to five words are still
// taken while the output waits. write config only while no word is in flight.
module fast_atan2_angle import fa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_I_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // grad_x [15:0], grad_y [31:16]
    input  logic                 s_tlast,   // last_in
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // angle_out [24:0], zero [31:25]
    output logic                 m_tlast    // last_out
);

    cfg_t             cfg_reg;
    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    item_t            fr_item;
    item_t            q_item;
    logic [ANG_W-1:0] angle;

    // config registers, unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree_mode <= 1'b1;
            cfg_reg.coef1       <= RST_COEF1;
            cfg_reg.coef3       <= RST_COEF3;
            cfg_reg.coef5       <= RST_COEF5;
            cfg_reg.coef7       <= RST_COEF7;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEGREE_MODE:  cfg_reg.degree_mode <= cfg_data[0];
                CFG_COEF_FIRST:   cfg_reg.coef1 <= cfg_data;
                CFG_COEF_THIRD:   cfg_reg.coef3 <= cfg_data;
                CFG_COEF_FIFTH:   cfg_reg.coef5 <= cfg_data;
                CFG_COEF_SEVENTH: cfg_reg.coef7 <= cfg_data;
                default:          ;
            endcase
        end
    end

    // front: abs and octant flags
    fa_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .grad_x   (s_tdata[15:0]),
        .grad_y   (s_tdata[31:16]),
        .last_in  (s_tlast),
        .push     (push),
        .full     (full),
        .item     (fr_item)
    );

    // decoupling fifo
    fa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_item   (fr_item),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .rd_item   (q_item)
    );

    // back: ratio, polynomial, fold, scale
    fa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .angle_out (angle),
        .last_out  (m_tlast)
    );

    assign m_tdata = {7'd0, angle};

endmodule

// ===== sv/fa_front.sv =====
// ----------------------------------------------------------------------------
// fa_front
// input stage: absolute values, octant classification, one register
// ----------------------------------------------------------------------------
module fa_front import fa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_WIDTH-1:0] grad_x,
    input  logic [IN_WIDTH-1:0] grad_y,
    input  logic                last_in,
    output logic                push,
    input  logic                full,
    output item_t               item
);

    logic                valid_reg;
    logic                valid_next;
    item_t               item_reg;
    item_t               item_next;
    logic [IN_WIDTH-1:0] ax;
    logic [IN_WIDTH-1:0] ay;
    logic                take;

    assign push     = valid_reg && !full;
    assign in_ready = !valid_reg || push;
    assign take     = in_valid && in_ready;
    assign item     = item_reg;

    always_comb
    begin
        ax = grad_x[IN_WIDTH-1] ? (~grad_x + IN_WIDTH'(1)) : grad_x;
        ay = grad_y[IN_WIDTH-1] ? (~grad_y + IN_WIDTH'(1)) : grad_y;
        item_next.tag.steep = ay > ax;
        item_next.tag.xneg  = grad_x[IN_WIDTH-1];
        item_next.tag.yneg  = grad_y[IN_WIDTH-1];
        item_next.tag.last  = last_in;
        // equal magnitudes stay on the direct branch
        item_next.mn = (ay > ax) ? ax : ay;
        item_next.mx = (ay > ax) ? ay : ax;
        valid_next   = take || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/fa_queue.sv =====
// ----------------------------------------------------------------------------
// fa_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module fa_queue import fa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t rd_item
);

    item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_pop;

    assign full      = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign do_pop    = pop && not_empty;
    assign rd_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== sv/fa_div.sv =====
// ----------------------------------------------------------------------------
// fa_div
// pipelined restoring divider, one quotient bit per stage: c = (mn << F) / mx
// ----------------------------------------------------------------------------
module fa_div import fa_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  item_t          in_item,
    output logic           out_valid,
    output logic [C_W-1:0] ratio,
    output tag_t           out_tag
);

    typedef struct packed {
        logic [IN_WIDTH:0]   rem;
        logic [IN_WIDTH-1:0] mx;
        logic [C_W-1:0]      q;
        logic                zero;
        tag_t                tag;
    } dstg_t;

    dstg_t dv_reg [C_W];
    dstg_t dv_next [C_W];
    dstg_t src [C_W];
    logic  vl_reg [C_W];

    always_comb
    begin
        src[0].rem  = {1'b0, in_item.mn};
        src[0].mx   = in_item.mx;
        src[0].q    = '0;
        src[0].zero = in_item.mx == '0;
        src[0].tag  = in_item.tag;
    end

    for (genvar k = 0; k < C_W; k++)
    begin : g_stg
        logic [IN_WIDTH:0] r_sh;
        logic              ge;

        if (k > 0)
        begin : g_src
            assign src[k] = dv_reg[k-1];
        end

        always_comb
        begin
            // remainder stays below mx, so the shift never overflows
            r_sh = (k == 0) ? src[k].rem : {src[k].rem[IN_WIDTH-1:0], 1'b0};
            ge   = r_sh >= {1'b0, src[k].mx};
            dv_next[k]     = src[k];
            dv_next[k].rem = ge ? r_sh - {1'b0, src[k].mx} : r_sh;
            dv_next[k].q   = {src[k].q[C_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vl_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vl_reg[k] <= (k == 0) ? in_valid : vl_reg[k-1 < 0 ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // both inputs zero: ratio is taken as zero
    assign ratio     = dv_reg[C_W-1].zero ? '0 : dv_reg[C_W-1].q;
    assign out_tag   = dv_reg[C_W-1].tag;
    assign out_valid = vl_reg[C_W-1];

endmodule

// ===== sv/fa_back.sv =====
// ----------------------------------------------------------------------------
// fa_back
// divider, polynomial, octant fold, saturation, radian scale, output register
// ----------------------------------------------------------------------------
module fa_back import fa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  item_t            in_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ANG_W-1:0] angle_out,
    output logic             last_out
);

    typedef struct packed {
        logic [C_W-1:0] c;
        logic [C_W-1:0] c2;
        tag_t           tag;
    } car_t;

    logic                     adv;
    logic                     dv_valid;
    logic [C_W-1:0]           dv_c;
    tag_t                     dv_tag;
    logic                     bv_reg [BK_STG];
    logic [2*C_W-1:0]         sq;
    car_t                     s1_reg;
    car_t                     cm_reg [4];
    car_t                     ca_reg [4];
    logic signed [PRD_W-1:0]  mp_reg [4];
    logic signed [ACC_W-1:0]  ac_reg [4];
    logic signed [FLD_W-1:0]  fd_reg;
    tag_t                     fd_tag_reg;
    logic [ANG_W-1:0]         st_reg;
    tag_t                     st_tag_reg;
    logic [ANG_W-1:0]         rm_ang_reg;
    logic [RAD_P_W-1:0]       rm_prd_reg;
    tag_t                     rm_tag_reg;
    logic                     ov_reg;
    logic [ANG_W-1:0]         ang_reg;
    logic                     last_reg;
    logic [ANG_W-1:0]         ang_next;
    logic signed [FLD_W-1:0]  fd_next;
    logic [ANG_W-1:0]         st_next;
    logic [RAD_P_W:0]         rad_sum;

    assign adv       = !ov_reg || out_ready;
    assign pop       = adv;
    assign out_valid = ov_reg;
    assign angle_out = ang_reg;
    assign last_out  = last_reg;

    fa_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (dv_valid),
        .ratio     (dv_c),
        .out_tag   (dv_tag)
    );

    assign sq = dv_c * dv_c;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.c   <= dv_c;
            s1_reg.c2  <= sq[FRAC_BITS +: C_W];
            s1_reg.tag <= dv_tag;
        end
    end

    // horner steps: multiply stage, then round and add stage
    for (genvar j = 0; j < 4; j++)
    begin : g_hrn
        logic signed [ACC_W-1:0]  m_a;
        logic signed [C_W:0]      m_b;
        logic signed [ACC_W-1:0]  addc;
        logic signed [PRD_W-1:0]  rnd;
        car_t                     cin;

        if (j == 0)
        begin : g_first
            assign cin = s1_reg;
            assign m_a = ACC_W'(cfg.coef7);
        end
        else
        begin : g_next
            assign cin = ca_reg[j-1];
            assign m_a = ac_reg[j-1];
        end

        always_comb
        begin
            m_b  = (j == 3) ? $signed({1'b0, cin.c}) : $signed({1'b0, cin.c2});
            case (j)
                0:       addc = ACC_W'(cfg.coef5);
                1:       addc = ACC_W'(cfg.coef3);
                2:       addc = ACC_W'(cfg.coef1);
                default: addc = '0;
            endcase
            rnd = (mp_reg[j] + $signed(RND_HALF)) >>> FRAC_BITS;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mp_reg[j] <= PRD_W'(m_a) * PRD_W'(m_b);
                cm_reg[j] <= cin;
                ac_reg[j] <= rnd[ACC_W-1:0] + addc;
                ca_reg[j] <= cm_reg[j];
            end
        end
    end

    always_comb
    begin
        fd_next = FLD_W'(ac_reg[3]);
        if (ca_reg[3].tag.steep)
        begin
            fd_next = $signed(DEG90) - fd_next;
        end
        if (ca_reg[3].tag.xneg)
        begin
            fd_next = $signed(DEG180) - fd_next;
        end
        if (ca_reg[3].tag.yneg)
        begin
            fd_next = $signed(DEG360) - fd_next;
        end
        if (fd_reg < 0)
        begin
            st_next = '0;
        end
        else if (fd_reg > $signed(FLD_W'(ANGLE_MAX)))
        begin
            st_next = ANGLE_MAX;
        end
        else
        begin
            st_next = fd_reg[ANG_W-1:0];
        end
        rad_sum  = {1'b0, rm_prd_reg} + RAD_HALF;
        ang_next = cfg.degree_mode ? rm_ang_reg : ANG_W'(rad_sum[RAD_P_W:32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fd_reg     <= fd_next;
            fd_tag_reg <= ca_reg[3].tag;
            st_reg     <= st_next;
            st_tag_reg <= fd_tag_reg;
            rm_ang_reg <= st_reg;
            rm_prd_reg <= st_reg * DEG_TO_RAD;
            rm_tag_reg <= st_tag_reg;
            ang_reg    <= ang_next;
            last_reg   <= rm_tag_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BK_STG; i++)
            begin
                bv_reg[i] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg[0] <= dv_valid;
            for (int i = 1; i < BK_STG; i++)
            begin
                bv_reg[i] <= bv_reg[i-1];
            end
            ov_reg <= bv_reg[BK_STG-1];
        end
    end

endmodule

// ===== sv/fa_check.sv =====
// ----------------------------------------------------------------------------
// fa_check
// port-level checks of the atan2 angle block
// ----------------------------------------------------------------------------
module fa_check import fa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [31:0]        m_tdata,
    input logic               m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("padding bits of result not zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[24:0] <= 25'd23592960)
        else $error("angle above 360 degrees");

endmodule

bind fast_atan2_angle fa_check u_check (.*);
